// ===== hw/rtl/bfies_pkg.sv =====
// ----------------------------------------------------------------------------
// bfies_pkg
// shared codes, widths and control/status bundles of the bit field store
// ----------------------------------------------------------------------------
package bfies_pkg;

    // fixed field widths of the request and result words
    localparam int REQ_W   = 2;
    localparam int START_W = 12;
    localparam int FIELD_W = 6;
    localparam int DATA_W  = 32;
    localparam int BYTE_W  = 8;
    localparam int OFFS_W  = 3;

    // default sizes
    localparam int STORE_BITS_DEF     = 4096;
    localparam int MAX_FIELD_BITS_DEF = 32;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_GET  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SET  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FLIP = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load;     // latch request and precompute masks
        logic clr_we;   // clearing pass: zero one byte
        logic rd_en;    // issue next byte read of the span
        logic finish;   // register the result word
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;  // clearing pass at its last byte
        logic skip;      // range error or no-op: no store access
        logic rd_more;   // span bytes still to be read
        logic proc_last; // last span byte is in the byte lane this cycle
    } dp_stat_t;

endpackage

// ===== hw/rtl/bfies_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfies_ctrl
// sequencer: clearing pass, request accept, byte-by-byte span walk
// ----------------------------------------------------------------------------
module bfies_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  bfies_pkg::dp_stat_t  stat,
    output bfies_pkg::ctrl_cmd_t cmd
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_we = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (stat.skip)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.rd_en = stat.rd_more;
                    if (stat.proc_last)
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== hw/rtl/bfies_dp.sv =====
// ----------------------------------------------------------------------------
// bfies_dp
// byte store, request setup, read-modify-write byte lane and result window
// ----------------------------------------------------------------------------
module bfies_dp #(
    parameter int STORE_BITS     = bfies_pkg::STORE_BITS_DEF,
    parameter int MAX_FIELD_BITS = bfies_pkg::MAX_FIELD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bfies_pkg::ctrl_cmd_t                cmd,
    output bfies_pkg::dp_stat_t                 stat,
    input  logic [bfies_pkg::REQ_W-1:0]         req_type,
    input  logic [bfies_pkg::START_W-1:0]       bit_pos,
    input  logic [bfies_pkg::FIELD_W-1:0]       field_width,
    input  logic [bfies_pkg::DATA_W-1:0]        write_data,
    output logic                                done,
    output logic [bfies_pkg::DATA_W-1:0]        read_data,
    output logic                                range_error
);

    localparam int BW          = bfies_pkg::BYTE_W;
    localparam int STORE_BYTES = (STORE_BITS + BW - 1) / BW;
    localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int NB_MAX      = (MAX_FIELD_BITS + 2 * (BW - 1)) / BW;
    localparam int WIN_W       = NB_MAX * BW;
    localparam int CNT_W       = $clog2(NB_MAX + 1);
    localparam int IDX_W       = (NB_MAX > 1) ? $clog2(NB_MAX) : 1;
    localparam int WW          = $clog2(MAX_FIELD_BITS + 1);
    localparam int OW          = bfies_pkg::OFFS_W;

    // byte store
    logic [BW-1:0]     mem [STORE_BYTES];
    logic [BW-1:0]     rdata_reg;

    // clearing pass
    logic [ADDR_W-1:0] clr_cnt_reg;

    // request setup
    logic [bfies_pkg::REQ_W-1:0] kind_reg;
    logic [OW-1:0]     offs_reg;
    logic [ADDR_W-1:0] first_reg;
    logic [CNT_W-1:0]  nb_reg;
    logic [WIN_W-1:0]  bmask_reg;
    logic [WIN_W-1:0]  ins_reg;
    logic [bfies_pkg::DATA_W-1:0] fm32_reg;
    logic              err_reg;
    logic              skip_reg;

    // span walk
    logic [CNT_W-1:0]  rd_cnt_reg;
    logic              proc_reg;
    logic [IDX_W-1:0]  pidx_reg;
    logic [WIN_W-1:0]  win_reg;
    logic [WIN_W-1:0]  win_next;

    // result word
    logic              done_reg;
    logic [bfies_pkg::DATA_W-1:0] read_data_reg;
    logic              range_error_reg;

    // setup terms
    logic [WW-1:0]     w_eff;
    logic [WIN_W-1:0]  fm;
    logic              err_in;
    logic              noop_in;
    logic [CNT_W-1:0]  nb_in;

    // byte lane
    logic [BW-1:0]     m_b;
    logic [BW-1:0]     ins_b;
    logic [BW-1:0]     new_b;
    logic [BW-1:0]     cap_b;
    logic              wr_en;
    logic [ADDR_W-1:0] raddr;
    logic [ADDR_W-1:0] waddr;
    logic [bfies_pkg::DATA_W-1:0] res;

    // saturated width, field mask, span length and range check
    always_comb
    begin
        if (req_type == bfies_pkg::REQ_FLIP)
        begin
            w_eff = WW'(1);
        end
        else if (32'(field_width) > 32'(MAX_FIELD_BITS))
        begin
            w_eff = WW'(MAX_FIELD_BITS);
        end
        else
        begin
            w_eff = WW'(field_width);
        end
        for (int i = 0; i < WIN_W; i++)
        begin
            fm[i] = (32'(i) < 32'(w_eff));
        end
        nb_in   = CNT_W'((32'(bit_pos[OW-1:0]) + 32'(w_eff) + 32'(BW - 1)) / BW);
        noop_in = (req_type == bfies_pkg::REQ_NONE) || (w_eff == '0);
        err_in  = !noop_in && ((32'(bit_pos) + 32'(w_eff)) > 32'(STORE_BITS));
    end

    // one byte of the span: merge for set, invert for flip, capture into the result window
    always_comb
    begin
        m_b   = '0;
        ins_b = '0;
        for (int j = 0; j < NB_MAX; j++)
        begin
            if (IDX_W'(j) == pidx_reg)
            begin
                m_b   = bmask_reg[j*BW +: BW];
                ins_b = ins_reg[j*BW +: BW];
            end
        end
        if (kind_reg == bfies_pkg::REQ_FLIP)
        begin
            new_b = rdata_reg ^ m_b;
            cap_b = new_b;
        end
        else
        begin
            new_b = (rdata_reg & ~m_b) | ins_b;
            cap_b = rdata_reg;
        end
        win_next = win_reg;
        for (int j = 0; j < NB_MAX; j++)
        begin
            if (proc_reg && (IDX_W'(j) == pidx_reg))
            begin
                win_next[j*BW +: BW] = cap_b;
            end
        end
        res = bfies_pkg::DATA_W'(win_next >> offs_reg) & fm32_reg;
    end

    assign wr_en = proc_reg && ((kind_reg == bfies_pkg::REQ_SET) ||
                                (kind_reg == bfies_pkg::REQ_FLIP));
    assign raddr = first_reg + ADDR_W'(rd_cnt_reg);
    assign waddr = first_reg + ADDR_W'(pidx_reg);

    // store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.clr_we)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[waddr] <= new_b;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= req_type;
            offs_reg  <= bit_pos[OW-1:0];
            first_reg <= ADDR_W'(bit_pos >> OW);
            nb_reg    <= nb_in;
            bmask_reg <= fm << bit_pos[OW-1:0];
            ins_reg   <= (WIN_W'(write_data) & fm) << bit_pos[OW-1:0];
            fm32_reg  <= bfies_pkg::DATA_W'(fm);
            err_reg   <= err_in;
        end
        if (proc_reg)
        begin
            win_reg <= win_next;
        end
        if (cmd.rd_en)
        begin
            pidx_reg <= IDX_W'(rd_cnt_reg);
        end
        if (cmd.finish)
        begin
            if (skip_reg || (kind_reg == bfies_pkg::REQ_SET))
            begin
                read_data_reg <= '0;
            end
            else
            begin
                read_data_reg <= res;
            end
            range_error_reg <= err_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            rd_cnt_reg  <= '0;
            proc_reg    <= 1'b0;
            skip_reg    <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.clr_we)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.load)
            begin
                rd_cnt_reg <= '0;
                skip_reg   <= err_in || noop_in;
            end
            else if (cmd.rd_en)
            begin
                rd_cnt_reg <= rd_cnt_reg + 1'b1;
            end
            proc_reg <= cmd.rd_en;
            done_reg <= cmd.finish;
        end
    end

    assign stat.clr_last  = (clr_cnt_reg == ADDR_W'(STORE_BYTES - 1));
    assign stat.skip      = skip_reg;
    assign stat.rd_more   = (rd_cnt_reg < nb_reg);
    assign stat.proc_last = proc_reg && (32'(pidx_reg) + 1 == 32'(nb_reg));

    assign done        = done_reg;
    assign read_data   = read_data_reg;
    assign range_error = range_error_reg;

    // no store access after a rejected or empty request
    a_skip_no_access: assert property (@(posedge clk) disable iff (!rst_n)
        skip_reg |-> !cmd.rd_en && !proc_reg)
        else $error("store accessed for a skipped request");

    // reads never run past the span
    a_rd_in_span: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> (rd_cnt_reg < nb_reg))
        else $error("byte read beyond the field span");

    // a range error always reports a zero field
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && range_error_reg) |-> (read_data_reg == '0))
        else $error("range error with nonzero read data");

endmodule

// ===== hw/rtl/bit_field_insert_extract_store.sv =====
// ----------------------------------------------------------------------------
// bit_field_insert_extract_store
// bit-addressed byte store with field get, field set and single-bit flip
// ----------------------------------------------------------------------------
//
//  channel   handshake              word
//  -------   ---------------------  ----------------------------------------
//  request   start && !busy         req_type, bit_pos, field_width,
//                                   write_data
//  result    done (one cycle)       read_data, range_error
//
//  a request touching n bytes (n = ceil((bit_pos%8 + width)/8), 1..5 for
//  fields of up to 32 bits) is walked to its last byte before the next
//  accept; the byte store has one read and one write port, so the span is
//  walked one byte per cycle with the read of byte k+1 overlapping the
//  write of byte k
//  rejected and empty requests skip the span walk and touch no store byte
//  after reset the store is zeroed by a clearing pass over every byte,
//  during which busy stays high
//  done rises in the cycle busy drops; the receiver cannot stall, so a
//  result word is shown exactly once
//
module bit_field_insert_extract_store #(
    parameter int STORE_BITS     = bfies_pkg::STORE_BITS_DEF,
    parameter int MAX_FIELD_BITS = bfies_pkg::MAX_FIELD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request word
    input  logic                          start,
    output logic                          busy,
    input  logic [bfies_pkg::REQ_W-1:0]   req_type,
    input  logic [bfies_pkg::START_W-1:0] bit_pos,
    input  logic [bfies_pkg::FIELD_W-1:0] field_width,
    input  logic [bfies_pkg::DATA_W-1:0]  write_data,
    // result word
    output logic                          done,
    output logic [bfies_pkg::DATA_W-1:0]  read_data,
    output logic                          range_error
);

    // command and status between sequencer and datapath
    bfies_pkg::ctrl_cmd_t cmd;
    bfies_pkg::dp_stat_t  stat;

    // sequencer: clearing pass, accept, span walk
    bfies_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // datapath: store, masks, byte lane, result register
    bfies_dp #(
        .STORE_BITS     (STORE_BITS),
        .MAX_FIELD_BITS (MAX_FIELD_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .req_type    (req_type),
        .bit_pos     (bit_pos),
        .field_width (field_width),
        .write_data  (write_data),
        .done        (done),
        .read_data   (read_data),
        .range_error (range_error)
    );

    // a result word comes out only once the block is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word while busy");

    // an accepted request always occupies the block
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not start work");

endmodule

// ===== bench/bfies_result_checker.sv =====
// ----------------------------------------------------------------------------
// bfies_result_checker
// watches the request and result channels of the bit field store, keeps its
// own copy of the store, and compares every result word with the prediction
// ----------------------------------------------------------------------------
module bfies_result_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [bfies_pkg::REQ_W-1:0]   req_type,
    input  logic [bfies_pkg::START_W-1:0] bit_pos,
    input  logic [bfies_pkg::FIELD_W-1:0] field_width,
    input  logic [bfies_pkg::DATA_W-1:0]  write_data,
    input  logic                          done,
    input  logic [bfies_pkg::DATA_W-1:0]  read_data,
    input  logic                          range_error,
    output int                            mismatches,
    output int                            pending
);

    localparam int STORE_BYTES = bfies_pkg::STORE_BITS_DEF / bfies_pkg::BYTE_W;

    typedef struct packed {
        logic [bfies_pkg::DATA_W-1:0] read_data;
        logic                         range_error;
    } field_result_t;

    logic [bfies_pkg::BYTE_W-1:0] shadow_store [STORE_BYTES];
    field_result_t                expected_words [$];
    int                           reported = 0;
    int                           error_count = 0;
    int                           queued = 0;

    assign mismatches = error_count;
    assign pending    = queued;

    function automatic logic read_store_bit(input int pos);
        return shadow_store[pos / bfies_pkg::BYTE_W][pos % bfies_pkg::BYTE_W];
    endfunction

    // applies one request to the shadow store and returns its result word
    function automatic field_result_t apply_field_access(
        input logic [bfies_pkg::REQ_W-1:0]   kind,
        input logic [bfies_pkg::START_W-1:0] pos,
        input logic [bfies_pkg::FIELD_W-1:0] width_in,
        input logic [bfies_pkg::DATA_W-1:0]  data
    );
        field_result_t res;
        int            width;
        int            p;
        logic          new_bit;
        res.read_data   = '0;
        res.range_error = 1'b0;
        width = (kind == bfies_pkg::REQ_FLIP) ? 1 : int'(width_in);
        if (width > bfies_pkg::MAX_FIELD_BITS_DEF)
            width = bfies_pkg::MAX_FIELD_BITS_DEF;
        if (kind != bfies_pkg::REQ_NONE && width != 0)
        begin
            if (int'(pos) + width > bfies_pkg::STORE_BITS_DEF)
            begin
                res.range_error = 1'b1;
            end
            else if (kind == bfies_pkg::REQ_GET)
            begin
                for (int i = 0; i < width; i++)
                    res.read_data[i] = read_store_bit(int'(pos) + i);
            end
            else if (kind == bfies_pkg::REQ_SET)
            begin
                for (int i = 0; i < width; i++)
                begin
                    p = int'(pos) + i;
                    shadow_store[p / bfies_pkg::BYTE_W][p % bfies_pkg::BYTE_W] = data[i];
                end
            end
            else
            begin
                p = int'(pos);
                new_bit = ~read_store_bit(p);
                shadow_store[p / bfies_pkg::BYTE_W][p % bfies_pkg::BYTE_W] = new_bit;
                res.read_data[0] = new_bit;
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        field_result_t want;
        if (!rst_n)
        begin
            for (int b = 0; b < STORE_BYTES; b++)
                shadow_store[b] = '0;
            expected_words.delete();
            queued = 0;
        end
        else
        begin
            // result side first: a word shown now belongs to an earlier request
            if (done)
            begin
                if (expected_words.size() == 0)
                begin
                    error_count++;
                    if (reported < 10)
                    begin
                        reported++;
                        $display("unexpected result word: read_data=%h range_error=%b",
                                 read_data, range_error);
                    end
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (read_data !== want.read_data || range_error !== want.range_error)
                    begin
                        error_count++;
                        if (reported < 10)
                        begin
                            reported++;
                            $display({"result mismatch: read_data exp %h got %h, ",
                                      "range_error exp %b got %b"},
                                     want.read_data, read_data,
                                     want.range_error, range_error);
                        end
                    end
                end
            end
            if (start && !busy)
                expected_words.push_back(
                    apply_field_access(req_type, bit_pos, field_width, write_data));
            queued = expected_words.size();
        end
    end

endmodule

// ===== bench/bit_field_insert_extract_store_tb.sv =====
// ----------------------------------------------------------------------------
// bit_field_insert_extract_store_tb
// drives get, set, flip and unused-kind requests into the bit field store with random
// gaps, a directed opening and a long random run; a checker beside the block
// predicts each result word and counts mismatches for the verdict
// ----------------------------------------------------------------------------
module bit_field_insert_extract_store_tb;

    localparam int CLK_PERIOD   = 8;
    localparam int RANDOM_WORDS = 1000;
    // clearing pass, ~1000 words with their idle gaps and busy time, many times over
    localparam int LIMIT_CYCLES = 400000;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic [bfies_pkg::REQ_W-1:0]   req_type;
    logic [bfies_pkg::START_W-1:0] bit_pos;
    logic [bfies_pkg::FIELD_W-1:0] field_width;
    logic [bfies_pkg::DATA_W-1:0]  write_data;
    logic                          done;
    logic [bfies_pkg::DATA_W-1:0]  read_data;
    logic                          range_error;

    int                 mismatches;
    int                 pending;
    bit                 no_idle;

    bit_field_insert_extract_store u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .bit_pos     (bit_pos),
        .field_width (field_width),
        .write_data  (write_data),
        .done        (done),
        .read_data   (read_data),
        .range_error (range_error)
    );

    bfies_result_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .bit_pos     (bit_pos),
        .field_width (field_width),
        .write_data  (write_data),
        .done        (done),
        .read_data   (read_data),
        .range_error (range_error),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // hard stop in case the block hangs or drops a word
    initial
    begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("Mismatches found");
        $finish;
    end

    // present one request word at a falling edge and hold it until accepted;
    // called and returning just after a falling edge
    task automatic send_request(
        input logic [bfies_pkg::REQ_W-1:0]   kind,
        input logic [bfies_pkg::START_W-1:0] pos,
        input logic [bfies_pkg::FIELD_W-1:0] width,
        input logic [bfies_pkg::DATA_W-1:0]  data
    );
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start       <= 1'b1;
        req_type    <= kind;
        bit_pos     <= pos;
        field_width <= width;
        write_data  <= data;
        // accepted at the rising edge where busy is low
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    // mostly legal requests in a small hot window so gets see earlier sets,
    // with some whole-store, end-of-store, empty and oversized requests
    task automatic send_random_request();
        logic [bfies_pkg::REQ_W-1:0]   kind;
        logic [bfies_pkg::START_W-1:0] pos;
        logic [bfies_pkg::FIELD_W-1:0] width;
        int                            pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            kind = bfies_pkg::REQ_GET;
        else if (pick < 75)
            kind = bfies_pkg::REQ_SET;
        else if (pick < 93)
            kind = bfies_pkg::REQ_FLIP;
        else
            kind = bfies_pkg::REQ_NONE;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            pos = bfies_pkg::START_W'($urandom_range(0, 255));
        else if (pick < 85)
            pos = bfies_pkg::START_W'($urandom_range(0, bfies_pkg::STORE_BITS_DEF - 1));
        else
            pos = bfies_pkg::START_W'($urandom_range(bfies_pkg::STORE_BITS_DEF - 56,
                                                     bfies_pkg::STORE_BITS_DEF - 1));
        pick = $urandom_range(0, 99);
        if (pick < 85)
            width = bfies_pkg::FIELD_W'($urandom_range(1, bfies_pkg::MAX_FIELD_BITS_DEF));
        else if (pick < 92)
            width = '0;
        else
            width = bfies_pkg::FIELD_W'($urandom_range(bfies_pkg::MAX_FIELD_BITS_DEF + 1, 63));
        send_request(kind, pos, width, $urandom);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        req_type    = bfies_pkg::REQ_GET;
        bit_pos     = '0;
        field_width = '0;
        write_data  = '0;
        no_idle     = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed opening: store starts cleared
        send_request(bfies_pkg::REQ_GET,  12'd0,    6'd32, 32'h0000_0000);
        send_request(bfies_pkg::REQ_SET,  12'd0,    6'd32, 32'hFFFF_FFFF);
        send_request(bfies_pkg::REQ_GET,  12'd0,    6'd32, 32'h0000_0000);
        // unaligned five-byte span, then read back across it
        send_request(bfies_pkg::REQ_SET,  12'd45,   6'd32, 32'hA5C3_0F96);
        send_request(bfies_pkg::REQ_GET,  12'd43,   6'd32, 32'h0000_0000);
        send_request(bfies_pkg::REQ_GET,  12'd45,   6'd1,  32'h0000_0000);
        // field that ends exactly at the top of the store
        send_request(bfies_pkg::REQ_SET,  12'd4064, 6'd32, 32'h8000_0001);
        send_request(bfies_pkg::REQ_GET,  12'd4064, 6'd32, 32'h0000_0000);
        // just past the end: range errors; fields that end exactly at the top: none
        send_request(bfies_pkg::REQ_GET,  12'd4065, 6'd32, 32'h0000_0000);
        send_request(bfies_pkg::REQ_SET,  12'd4090, 6'd10, 32'hFFFF_FFFF);
        send_request(bfies_pkg::REQ_GET,  12'd4088, 6'd8,  32'h0000_0000);
        send_request(bfies_pkg::REQ_SET,  12'd4095, 6'd1,  32'h0000_0000);
        send_request(bfies_pkg::REQ_FLIP, 12'd4095, 6'd63, 32'h0000_0000);
        send_request(bfies_pkg::REQ_FLIP, 12'd4095, 6'd0,  32'h0000_0000);
        send_request(bfies_pkg::REQ_FLIP, 12'd0,    6'd5,  32'hFFFF_FFFF);
        // zero-width get and set do nothing
        send_request(bfies_pkg::REQ_SET,  12'd100,  6'd0,  32'hFFFF_FFFF);
        send_request(bfies_pkg::REQ_GET,  12'd100,  6'd0,  32'h0000_0000);
        // unused request kind
        send_request(bfies_pkg::REQ_NONE, 12'd4095, 6'd63, 32'hFFFF_FFFF);
        // oversized widths saturate to 32 bits
        send_request(bfies_pkg::REQ_SET,  12'd200,  6'd40, 32'hDEAD_BEEF);
        send_request(bfies_pkg::REQ_GET,  12'd200,  6'd63, 32'h0000_0000);
        send_request(bfies_pkg::REQ_GET,  12'd4064, 6'd63, 32'h0000_0000);
        send_request(bfies_pkg::REQ_GET,  12'd4065, 6'd33, 32'h0000_0000);
        send_request(bfies_pkg::REQ_SET,  12'd7,    6'd32, 32'h0000_0000);
        send_request(bfies_pkg::REQ_GET,  12'd0,    6'd32, 32'h0000_0000);

        // random run, with back-to-back stretches and one full drain
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 100 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            if (n == RANDOM_WORDS / 2)
            begin
                start <= 1'b0;
                while (pending != 0)
                    @(negedge clk);
            end
            send_random_request();
        end
        start <= 1'b0;

        // drain, then wait for anything stray
        while (pending != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
